[src/kdlp_pkg.sv]
// Shared types and constants for the key debouncer with long press and auto-repeat.
// No dependencies; imported by the interfaces, the per-key unit and the top level.
package kdlp_pkg;

	localparam int KEY_CODE_W = 3;
	localparam int DEB_W      = 8;
	localparam int LONG_W     = 16;
	localparam int PERIOD_W   = 16;
	localparam int MASK_W     = 4;
	localparam int HOLD_W     = 8;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam logic [HOLD_W-1:0]   HOLD_MAX       = 8'hFF;
	localparam logic [DEB_W-1:0]    DEBOUNCE_RST   = 8'd5;
	localparam logic [LONG_W-1:0]   LONG_RST       = 16'd1000;
	localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd100;
	localparam logic [MASK_W-1:0]   MASK_RST       = 4'd3;

	// register index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_PERIOD   = 2'd2,
		REG_MASK     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DEB_W-1:0]    debounce_ticks;
		logic [LONG_W-1:0]   long_press_ticks;
		logic [PERIOD_W-1:0] repeat_period;
		logic [MASK_W-1:0]   repeat_key_mask;
	} cfg_t;

endpackage

[src/kdlp_if.sv]
// Valid/ready channel interfaces: scan word in, key code word out.
// Depends on kdlp_pkg.
interface kdlp_in_if
	import kdlp_pkg::*;
#(
	parameter int NUM_KEYS = 4
);
	logic                valid;
	logic                ready;
	logic [NUM_KEYS-1:0] key_levels;
	logic                repeat_enable;

	modport source (output valid, key_levels, repeat_enable, input ready);
	modport sink   (input valid, key_levels, repeat_enable, output ready);
endinterface

interface kdlp_out_if
	import kdlp_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [KEY_CODE_W-1:0] key_code;

	modport source (output valid, key_code, input ready);
	modport sink   (input valid, key_code, output ready);
endinterface

[src/kdlp_key.sv]
// Per-key debounce, press timer, long-press flag and repeat phase.
// Depends on kdlp_pkg; instantiated once per key by the top level.
module kdlp_key
	import kdlp_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,      // one scan tick is applied
	input  logic now,       // raw level this tick, 0 = pressed
	input  logic may_repeat,
	input  cfg_t cfg,
	output logic fire       // key reports this tick
);

	localparam int CW = (TIMER_BITS > LONG_W) ? TIMER_BITS : LONG_W;

	logic                  prev_q;
	logic [HOLD_W-1:0]     hold_q, hold_n;
	logic [TIMER_BITS-1:0] timer_q, timer_n;
	logic                  long_q, long_n;
	logic [TIMER_BITS-1:0] phase_q, phase_n, phase_inc;
	logic                  short_press, long_set, timer_long, deb_n;
	logic [CW-1:0]         timer_x, lp_x, phase_x, period_x;

	always_comb begin
		hold_n      = hold_q;
		timer_n     = timer_q;
		long_n      = long_q;
		phase_n     = phase_q;
		short_press = 1'b0;
		phase_inc   = phase_q + 1'b1;
		phase_x     = CW'(phase_inc);
		period_x    = CW'(cfg.repeat_period);
		lp_x        = CW'(cfg.long_press_ticks);

		if (prev_q && !now) begin
			// falling edge: new press
			hold_n  = HOLD_W'(1);
			timer_n = '0;
			long_n  = 1'b0;
			phase_n = '0;
		end else if (!prev_q && !now) begin
			if (hold_q != HOLD_MAX)
				hold_n = hold_q + 1'b1;
			if (hold_n >= cfg.debounce_ticks) begin
				timer_n = timer_q + 1'b1;
				if (long_q)
					phase_n = (phase_x >= period_x) ? '0 : phase_inc;
			end
		end else if (!prev_q && now) begin
			// release
			short_press = (hold_q >= cfg.debounce_ticks) &&
				(CW'(timer_q) < lp_x) && !long_q;
			hold_n  = '0;
			timer_n = '0;
			long_n  = 1'b0;
			phase_n = '0;
		end

		timer_x    = CW'(timer_n);
		timer_long = timer_x >= lp_x;
		deb_n      = hold_n >= cfg.debounce_ticks;
		long_set   = deb_n && timer_long && !long_n;
		if (long_set) begin
			long_n  = 1'b1;
			phase_n = '0;
		end

		fire = short_press || (long_set && may_repeat) ||
			(long_n && may_repeat && timer_long && (phase_n == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b1;
			hold_q  <= '0;
			timer_q <= '0;
			long_q  <= 1'b0;
			phase_q <= '0;
		end else if (step) begin
			prev_q  <= now;
			hold_q  <= hold_n;
			timer_q <= timer_n;
			long_q  <= long_n;
			phase_q <= phase_n;
		end
	end

endmodule

[src/key_debounce_long_press_repeat.sv]
// Key debouncer with short press, long press and auto-repeat reporting.
// Each accepted word on key_in is one scan tick of NUM_KEYS active-low key levels plus the
// repeat-enable flag; exactly one word comes out on code_out for every tick, carrying key_code
// (0 = nothing, else index+1 of the reporting key; the highest-numbered key wins). A tick is
// registered at the input (_s1), then one pass of per-key logic updates the key state and loads
// the output register, and one tick is taken every cycle while the
// output side keeps taking words. The only limit on rate is downstream backpressure, which
// stalls the input stage. Registers sit on an APB port at byte addresses 0, 4, 8, 12:
// debounce_ticks (8b, reset 5), long_press_ticks (16b, reset 1000), repeat_period (16b,
// reset 100), repeat_key_mask (4b, reset 3). Write them only while the block is idle.
// Depends on kdlp_pkg, kdlp_if and kdlp_key.
module key_debounce_long_press_repeat
	import kdlp_pkg::*;
#(
	parameter int NUM_KEYS   = 4,
	parameter int TIMER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	kdlp_in_if.sink           key_in,
	kdlp_out_if.source        code_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// config registers
	cfg_t     cfg_q;
	reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.long_press_ticks <= LONG_RST;
			cfg_q.repeat_period    <= PERIOD_RST;
			cfg_q.repeat_key_mask  <= MASK_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_DEBOUNCE: cfg_q.debounce_ticks   <= pwdata[DEB_W-1:0];
				REG_LONG:     cfg_q.long_press_ticks <= pwdata[LONG_W-1:0];
				REG_PERIOD:   cfg_q.repeat_period    <= pwdata[PERIOD_W-1:0];
				REG_MASK:     cfg_q.repeat_key_mask  <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE: prdata = DATA_W'(cfg_q.debounce_ticks);
			REG_LONG:     prdata = DATA_W'(cfg_q.long_press_ticks);
			REG_PERIOD:   prdata = DATA_W'(cfg_q.repeat_period);
			REG_MASK:     prdata = DATA_W'(cfg_q.repeat_key_mask);
			default:      prdata = '0;
		endcase
	end

	// handshake: output register frees when empty or taken; input stage advances into it
	logic                  valid_s1;
	logic [NUM_KEYS-1:0]   keys_s1;
	logic                  enable_s1;
	logic                  out_valid_q;
	logic [KEY_CODE_W-1:0] code_q;
	logic                  out_free, step;

	assign out_free     = !out_valid_q || code_out.ready;
	assign step         = valid_s1 && out_free;
	assign key_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			keys_s1   <= key_in.key_levels;
			enable_s1 <= key_in.repeat_enable;
		end
	end

	// per-key state; keys past the mask width never repeat
	logic [NUM_KEYS-1:0] fire;

	for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
		logic masked;
		if (i < MASK_W) begin : g_mask
			assign masked = cfg_q.repeat_key_mask[i];
		end else begin : g_nomask
			assign masked = 1'b0;
		end

		kdlp_key #(
			.TIMER_BITS (TIMER_BITS)
		) u_key (
			.clk        (clk),
			.arst_n     (arst_n),
			.step       (step),
			.now        (keys_s1[i]),
			.may_repeat (enable_s1 && masked),
			.cfg        (cfg_q),
			.fire       (fire[i])
		);
	end

	// highest-numbered firing key wins
	logic [KEY_CODE_W-1:0] code_n;

	always_comb begin
		code_n = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (fire[i])
				code_n = KEY_CODE_W'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			code_q <= code_n;
	end

	assign code_out.valid    = out_valid_q;
	assign code_out.key_code = code_q;

endmodule
